// ===== rtl/mgtrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgtrs_pkg
// Shared constants, operation codes and types of the reservation set.
// ----------------------------------------------------------------------------
package mgtrs_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TIME_W   = 16;
    localparam int FUNC_W   = 3;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_GAP_INS = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PRED    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_MIN     = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_MAX     = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_LIST    = 3'd6;

    typedef struct packed {
        logic lt;    // a < b
        logic eq;    // a == b
        logic near;  // (a - b) < gap
    } cmp_res_t;

endpackage

// ===== rtl/mgtrs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgtrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mgtrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mgtrs_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgtrs_cmp
// Shared compare unit: less-than, equality and distance-below-gap test.
// ----------------------------------------------------------------------------
module mgtrs_cmp (
    input  logic [mgtrs_pkg::TIME_W-1:0] a,
    input  logic [mgtrs_pkg::TIME_W-1:0] b,
    input  logic [mgtrs_pkg::TIME_W-1:0] gap,
    output mgtrs_pkg::cmp_res_t          res
);

    logic [mgtrs_pkg::TIME_W:0] diff;

    assign diff     = {1'b0, a} - {1'b0, b};
    assign res.lt   = diff[mgtrs_pkg::TIME_W];
    assign res.eq   = (a == b);
    assign res.near = (diff[mgtrs_pkg::TIME_W-1:0] < gap);

endmodule

// ===== rtl/mgtrs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgtrs_ctrl
// Sequencer: binary search, neighbor checks, entry shifting and result output.
// ----------------------------------------------------------------------------
module mgtrs_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mgtrs_pkg::FUNC_W-1:0]  func,
    input  logic [mgtrs_pkg::TIME_W-1:0]  time_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [mgtrs_pkg::TIME_W-1:0]  result_time,
    output logic                          last,
    output logic [mgtrs_pkg::TIME_W-1:0]  cmp_a,
    output logic [mgtrs_pkg::TIME_W-1:0]  cmp_b,
    input  mgtrs_pkg::cmp_res_t           cmp_res,
    output logic                          ram_we,
    output logic [mgtrs_pkg::IDX_W-1:0]   ram_waddr,
    output logic [mgtrs_pkg::TIME_W-1:0]  ram_wdata,
    output logic                          ram_re,
    output logic [mgtrs_pkg::IDX_W-1:0]   ram_raddr,
    input  logic [mgtrs_pkg::TIME_W-1:0]  ram_rdata
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SRCH_RD  = 4'd1;
    localparam logic [3:0] S_SRCH_CMP = 4'd2;
    localparam logic [3:0] S_POST     = 4'd3;
    localparam logic [3:0] S_NBR_CHK  = 4'd4;
    localparam logic [3:0] S_NBL_RD   = 4'd5;
    localparam logic [3:0] S_NBL_CHK  = 4'd6;
    localparam logic [3:0] S_SH_RD    = 4'd7;
    localparam logic [3:0] S_SH_WR    = 4'd8;
    localparam logic [3:0] S_DEL_CHK  = 4'd9;
    localparam logic [3:0] S_DSH_RD   = 4'd10;
    localparam logic [3:0] S_DSH_WR   = 4'd11;
    localparam logic [3:0] S_VAL_OUT  = 4'd12;
    localparam logic [3:0] S_LIST_RD  = 4'd13;
    localparam logic [3:0] S_LIST_CHK = 4'd14;
    localparam logic [3:0] S_EMIT     = 4'd15;

    logic [3:0]                     state_reg, state_next;
    logic [mgtrs_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                           out_valid_reg, out_valid_next;

    logic [mgtrs_pkg::FUNC_W-1:0]   func_reg, func_next;
    logic [mgtrs_pkg::TIME_W-1:0]   t_reg, t_next;
    logic [mgtrs_pkg::CNT_W-1:0]    lo_reg, lo_next;
    logic [mgtrs_pkg::CNT_W-1:0]    hi_reg, hi_next;
    logic [mgtrs_pkg::CNT_W-1:0]    mid_reg, mid_next;
    logic [mgtrs_pkg::CNT_W-1:0]    cur_reg, cur_next;
    logic                           ok_reg, ok_next;
    logic [mgtrs_pkg::TIME_W-1:0]   time_reg, time_next;
    logic                           last_reg, last_next;
    logic                           more_reg, more_next;

    logic [mgtrs_pkg::CNT_W:0]      mid_sum;
    logic [mgtrs_pkg::CNT_W-1:0]    mid_calc;
    logic [mgtrs_pkg::CNT_W-1:0]    p_dec;
    logic [mgtrs_pkg::CNT_W-1:0]    cur_dec;
    logic [mgtrs_pkg::CNT_W-1:0]    cur_inc;
    logic [mgtrs_pkg::CNT_W-1:0]    count_dec;
    logic [mgtrs_pkg::CNT_W-1:0]    raddr_full;
    logic [mgtrs_pkg::CNT_W-1:0]    waddr_full;
    logic                           gap_mode;

    logic                           emit;
    logic                           e_ok;
    logic [mgtrs_pkg::TIME_W-1:0]   e_time;
    logic                           e_last;
    logic                           e_more;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc  = mid_sum[mgtrs_pkg::CNT_W:1];
    assign p_dec     = lo_reg - mgtrs_pkg::CNT_ONE;
    assign cur_dec   = cur_reg - mgtrs_pkg::CNT_ONE;
    assign cur_inc   = cur_reg + mgtrs_pkg::CNT_ONE;
    assign count_dec = count_reg - mgtrs_pkg::CNT_ONE;
    assign gap_mode  = (func_reg == mgtrs_pkg::FUNC_GAP_INS);

    assign ram_raddr = raddr_full[mgtrs_pkg::IDX_W-1:0];
    assign ram_waddr = waddr_full[mgtrs_pkg::IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        func_next      = func_reg;
        t_next         = t_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        cur_next       = cur_reg;
        ok_next        = ok_reg;
        time_next      = time_reg;
        last_next      = last_reg;
        more_next      = more_reg;

        ram_we     = 1'b0;
        ram_re     = 1'b0;
        raddr_full = '0;
        waddr_full = '0;
        ram_wdata  = t_reg;
        cmp_a      = ram_rdata;
        cmp_b      = t_reg;

        emit   = 1'b0;
        e_ok   = 1'b0;
        e_time = '0;
        e_last = 1'b1;
        e_more = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = func;
                    t_next    = time_value;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    case (func)
                        mgtrs_pkg::FUNC_INSERT,
                        mgtrs_pkg::FUNC_GAP_INS:
                        begin
                            if (count_reg == mgtrs_pkg::CNT_CAP)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SRCH_RD;
                            end
                        end
                        mgtrs_pkg::FUNC_DELETE,
                        mgtrs_pkg::FUNC_PRED,
                        mgtrs_pkg::FUNC_LIST:
                        begin
                            state_next = S_SRCH_RD;
                        end
                        mgtrs_pkg::FUNC_MIN:
                        begin
                            if (count_reg == '0)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                raddr_full = '0;
                                state_next = S_VAL_OUT;
                            end
                        end
                        mgtrs_pkg::FUNC_MAX:
                        begin
                            if (count_reg == '0)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                raddr_full = count_dec;
                                state_next = S_VAL_OUT;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end

            S_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_re     = 1'b1;
                    raddr_full = mid_calc;
                    mid_next   = mid_calc;
                    state_next = S_SRCH_CMP;
                end
                else
                begin
                    state_next = S_POST;
                end
            end

            S_SRCH_CMP:
            begin
                if (cmp_res.lt)
                begin
                    lo_next = mid_reg + mgtrs_pkg::CNT_ONE;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH_RD;
            end

            // lo_reg now holds the insertion position
            S_POST:
            begin
                case (func_reg)
                    mgtrs_pkg::FUNC_INSERT,
                    mgtrs_pkg::FUNC_GAP_INS:
                    begin
                        if (lo_reg < count_reg)
                        begin
                            ram_re     = 1'b1;
                            raddr_full = lo_reg;
                            state_next = S_NBR_CHK;
                        end
                        else
                        begin
                            state_next = S_NBL_RD;
                        end
                    end
                    mgtrs_pkg::FUNC_DELETE:
                    begin
                        if (lo_reg < count_reg)
                        begin
                            ram_re     = 1'b1;
                            raddr_full = lo_reg;
                            state_next = S_DEL_CHK;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    mgtrs_pkg::FUNC_PRED:
                    begin
                        if (lo_reg != '0)
                        begin
                            ram_re     = 1'b1;
                            raddr_full = p_dec;
                            state_next = S_VAL_OUT;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    mgtrs_pkg::FUNC_LIST:
                    begin
                        if (lo_reg < count_reg)
                        begin
                            cur_next   = lo_reg;
                            state_next = S_LIST_RD;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    default:
                    begin
                        emit = 1'b1;
                    end
                endcase
            end

            S_NBR_CHK:
            begin
                if (cmp_res.eq || (gap_mode && cmp_res.near))
                begin
                    emit = 1'b1;
                end
                else
                begin
                    state_next = S_NBL_RD;
                end
            end

            S_NBL_RD:
            begin
                if (gap_mode && (lo_reg != '0))
                begin
                    ram_re     = 1'b1;
                    raddr_full = p_dec;
                    state_next = S_NBL_CHK;
                end
                else
                begin
                    cur_next   = count_reg;
                    state_next = S_SH_RD;
                end
            end

            S_NBL_CHK:
            begin
                cmp_a = t_reg;
                cmp_b = ram_rdata;
                if (cmp_res.near)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    cur_next   = count_reg;
                    state_next = S_SH_RD;
                end
            end

            S_SH_RD:
            begin
                if (cur_reg > lo_reg)
                begin
                    ram_re     = 1'b1;
                    raddr_full = cur_dec;
                    state_next = S_SH_WR;
                end
                else
                begin
                    ram_we     = 1'b1;
                    waddr_full = lo_reg;
                    ram_wdata  = t_reg;
                    count_next = count_reg + mgtrs_pkg::CNT_ONE;
                    emit       = 1'b1;
                    e_ok       = 1'b1;
                    e_time     = t_reg;
                end
            end

            S_SH_WR:
            begin
                ram_we     = 1'b1;
                waddr_full = cur_reg;
                ram_wdata  = ram_rdata;
                cur_next   = cur_dec;
                state_next = S_SH_RD;
            end

            S_DEL_CHK:
            begin
                if (cmp_res.eq)
                begin
                    cur_next   = lo_reg + mgtrs_pkg::CNT_ONE;
                    state_next = S_DSH_RD;
                end
                else
                begin
                    emit = 1'b1;
                end
            end

            S_DSH_RD:
            begin
                if (cur_reg < count_reg)
                begin
                    ram_re     = 1'b1;
                    raddr_full = cur_reg;
                    state_next = S_DSH_WR;
                end
                else
                begin
                    count_next = count_dec;
                    emit       = 1'b1;
                    e_ok       = 1'b1;
                    e_time     = t_reg;
                end
            end

            S_DSH_WR:
            begin
                ram_we     = 1'b1;
                waddr_full = cur_dec;
                ram_wdata  = ram_rdata;
                cur_next   = cur_inc;
                state_next = S_DSH_RD;
            end

            S_VAL_OUT:
            begin
                emit   = 1'b1;
                e_ok   = 1'b1;
                e_time = ram_rdata;
            end

            S_LIST_RD:
            begin
                ram_re     = 1'b1;
                raddr_full = cur_reg;
                state_next = S_LIST_CHK;
            end

            // only the entry at the insertion position can equal the key
            S_LIST_CHK:
            begin
                cur_next = cur_inc;
                if (cmp_res.eq)
                begin
                    if (cur_inc >= count_reg)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        state_next = S_LIST_RD;
                    end
                end
                else
                begin
                    emit   = 1'b1;
                    e_ok   = 1'b1;
                    e_time = ram_rdata;
                    e_last = (cur_inc == count_reg);
                    e_more = (cur_inc != count_reg);
                end
            end

            S_EMIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = more_reg ? S_LIST_RD : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            ok_next        = e_ok;
            time_next      = e_ok ? e_time : '0;
            last_next      = e_last;
            more_next      = e_more;
            state_next     = S_EMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        t_reg    <= t_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        cur_reg  <= cur_next;
        ok_reg   <= ok_next;
        time_reg <= time_next;
        last_reg <= last_next;
        more_reg <= more_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign result_time = time_reg;
    assign last        = last_reg;

endmodule

// ===== rtl/min_gap_time_reservation_set.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_gap_time_reservation_set
// Ordered set of distinct reserved times with a minimum-gap insert rule.
// ----------------------------------------------------------------------------
// Input transactions (in_valid / in_stall) carry func and time_value; result
// transactions (out_valid / out_stall) carry ok, result_time and last. The
// min_gap register is written over cfg_valid / cfg_ready; the user must
// write it only while idle, as the block itself does not enforce this.
// One transaction is in work at a time; in_stall stays high until its last
// result has been taken. Times are held sorted in a RAM with a registered
// read port; search and list steps read one entry and pass it through the
// shared compare unit:
//   search:          binary search, one RAM read and one compare per step
//   insert / delete: search, a check of the neighbors (insert) or of the
//                    entry found (delete), then one read and one write per
//                    shifted entry
//   min / max:       one RAM read of the first or last entry
//   list later:      search, then one read and one compare per entry
// Results sit in an output register and hold while out_stall is high; the
// sequencer waits there. Reset empties the set and clears min_gap to 0; RAM
// contents are not cleared, since only entries below the count are read.
// ----------------------------------------------------------------------------
module min_gap_time_reservation_set (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mgtrs_pkg::FUNC_W-1:0]  func,
    input  logic [mgtrs_pkg::TIME_W-1:0]  time_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [mgtrs_pkg::TIME_W-1:0]  result_time,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mgtrs_pkg::TIME_W-1:0]  min_gap
);

    logic [mgtrs_pkg::TIME_W-1:0] min_gap_reg;
    logic [mgtrs_pkg::TIME_W-1:0] cmp_a;
    logic [mgtrs_pkg::TIME_W-1:0] cmp_b;
    mgtrs_pkg::cmp_res_t          cmp_res;
    logic                         ram_we;
    logic [mgtrs_pkg::IDX_W-1:0]  ram_waddr;
    logic [mgtrs_pkg::TIME_W-1:0] ram_wdata;
    logic                         ram_re;
    logic [mgtrs_pkg::IDX_W-1:0]  ram_raddr;
    logic [mgtrs_pkg::TIME_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            min_gap_reg <= min_gap;
        end
    end

    mgtrs_ram #(
        .WIDTH (mgtrs_pkg::TIME_W),
        .DEPTH (mgtrs_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mgtrs_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .gap (min_gap_reg),
        .res (cmp_res)
    );

    mgtrs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .time_value  (time_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .result_time (result_time),
        .last        (last),
        .cmp_a       (cmp_a),
        .cmp_b       (cmp_b),
        .cmp_res     (cmp_res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("input taken while a result is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block not busy after accepting a transaction");

    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> last)
        else $error("failure result not marked last");

    a_fail_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (result_time == '0))
        else $error("failure result carries a nonzero time");

endmodule
